// ===== rtl/pwm_duty_to_speed_code_core_defines.svh =====
// ----------------------------------------------------------------------------
// PWM duty to speed code: assertion macros
// Shared assertion forms, sampled on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PWM_DUTY_TO_SPEED_CODE_CORE_DEFINES_SVH
`define PWM_DUTY_TO_SPEED_CODE_CORE_DEFINES_SVH

// prop must hold at every clock edge out of reset
`define PDSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expr must never be true at a clock edge out of reset
`define PDSC_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== rtl/pdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// PWM duty to speed code: package
// Register indexes, reset values, arithmetic constants and divider types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdsc_pkg;

  localparam int unsigned CFG_W     = 28;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_STILL_BAND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_LOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_HIGH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ     = 3'd6;

  localparam logic [7:0]  RST_STILL_BAND   = 8'd2;
  localparam logic [11:0] RST_FULL_SCALE   = 12'd2000;
  localparam logic [19:0] RST_FORWARD_GAIN = 20'd150995;
  localparam logic [19:0] RST_REVERSE_GAIN = 20'd163185;
  localparam logic [10:0] RST_CODE_LOW     = 11'd192;
  localparam logic [10:0] RST_CODE_HIGH    = 11'd1792;
  localparam logic [27:0] RST_CLOCK_HZ     = 28'd72000000;

  localparam logic [10:0] STILL_CODE = 11'd1023;

  // base codes in Q16
  localparam logic signed [35:0] FWD_SUM_BASE = 36'sd67108864;
  localparam logic signed [35:0] REV_SUM_BASE = 36'sd66977792;

  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_DUTY_STEPS = 5'd12;
  localparam logic [DIV_CNT_W-1:0] DIV_FREQ_STEPS = 5'd28;

  typedef struct packed {
    logic                 start;
    logic [31:0]          rem_init;
    logic [27:0]          shift_init;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [27:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/pdsc_div.sv =====
// ----------------------------------------------------------------------------
// PWM duty to speed code: shared divider
// Restoring divider, one quotient bit per cycle against a 32-bit divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdsc_div import pdsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  input  logic [31:0] divisor_i,
  output div_rsp_t    rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]          rem_q, rem_d;
  logic [27:0]          sh_q, sh_d;
  logic [27:0]          quot_q, quot_d;
  logic [32:0]          shifted;
  logic [33:0]          trial;

  assign shifted = {rem_q, sh_q[27]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    sh_d   = sh_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = req_i.rem_init;
      sh_d   = req_i.shift_init;
      quot_d = '0;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d  = trial[31:0];
        quot_d = {quot_q[26:0], 1'b1};
      end else begin
        rem_d  = shifted[31:0];
        quot_d = {quot_q[26:0], 1'b0};
      end
      sh_d  = {sh_q[26:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      sh_q   <= '0;
      quot_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      sh_q   <= sh_d;
      quot_q <= quot_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== rtl/pwm_duty_to_speed_code_core.sv =====
// ----------------------------------------------------------------------------
// PWM duty to speed code: top level
// Turns a captured PWM period and high time into duty, frequency and a
// dead-banded speed code through Q16 forward and reverse gains.
// ----------------------------------------------------------------------------
// One word at a time: the shared restoring divider yields one quotient bit per
// cycle, 12 bits for the duty and 28 for the frequency. A word with a nonzero
// period and high time below the period runs both divisions; when the high
// time reaches the period the duty saturates without division and only the
// frequency is divided; a zero period skips the divider. Input ready returns
// in the same cycle as the result word turns valid; a result waiting on the
// output does not block the next word, only the completion of that next word.
`timescale 1ns / 1ps

module pwm_duty_to_speed_code_core import pdsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,  // period_ticks[31:0], high_ticks[63:32]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [55:0]          m_axis_tdata,  // duty_position[11:0], pwm_frequency[39:12],
                                              // speed_code[50:40], moved[51], saturated[52]
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,
    ST_DIVD  = 7'b0000100,
    ST_DIVF  = 7'b0001000,
    ST_DELTA = 7'b0010000,
    ST_SCALE = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [7:0]  still_band_q;
  logic [11:0] full_scale_q;
  logic [19:0] forward_gain_q;
  logic [19:0] reverse_gain_q;
  logic [10:0] code_low_q;
  logic [10:0] code_high_q;
  logic [27:0] clock_hz_q;

  logic [31:0] period_q, period_d;
  logic        high_ge_q, high_ge_d;
  logic [43:0] prod_q, prod_d;
  logic [11:0] duty_q, duty_d;
  logic [27:0] freq_q, freq_d;
  logic [11:0] acc_q, acc_d;
  logic signed [13:0] d_q, d_d;
  logic        moved_q, moved_d;
  logic signed [34:0] prod2_q, prod2_d;

  logic        out_valid_q, out_valid_d;
  logic [55:0] out_data_q, out_data_d;

  logic        in_fire;
  logic        out_free;
  logic        freq_sel;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic signed [13:0] raw;
  logic [13:0]        mag;
  logic signed [14:0] twice;
  logic signed [14:0] fs_s;
  logic signed [13:0] fs14;
  logic signed [20:0] gain_s;
  logic               fwd;
  logic signed [35:0] sum;
  logic [19:0]        code_full;
  logic [10:0]        code;
  logic               sat;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      still_band_q   <= RST_STILL_BAND;
      full_scale_q   <= RST_FULL_SCALE;
      forward_gain_q <= RST_FORWARD_GAIN;
      reverse_gain_q <= RST_REVERSE_GAIN;
      code_low_q     <= RST_CODE_LOW;
      code_high_q    <= RST_CODE_HIGH;
      clock_hz_q     <= RST_CLOCK_HZ;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STILL_BAND:   still_band_q   <= cfg_wdata_i[7:0];
        CFG_FULL_SCALE:   full_scale_q   <= cfg_wdata_i[11:0];
        CFG_FORWARD_GAIN: forward_gain_q <= cfg_wdata_i[19:0];
        CFG_REVERSE_GAIN: reverse_gain_q <= cfg_wdata_i[19:0];
        CFG_CODE_LOW:     code_low_q     <= cfg_wdata_i[10:0];
        CFG_CODE_HIGH:    code_high_q    <= cfg_wdata_i[10:0];
        CFG_CLOCK_HZ:     clock_hz_q     <= cfg_wdata_i[27:0];
        default: ;
      endcase
    end
  end

  // divider requests
  assign freq_sel = ((state_q == ST_PREP) && high_ge_q) || (state_q == ST_DIVD);

  always_comb begin
    div_req.start      = ((state_q == ST_PREP) && (period_q != '0)) ||
                         ((state_q == ST_DIVD) && div_rsp.done);
    div_req.rem_init   = freq_sel ? 32'd0 : prod_q[43:12];
    div_req.shift_init = freq_sel ? clock_hz_q : {prod_q[11:0], 16'd0};
    div_req.steps      = freq_sel ? DIV_FREQ_STEPS : DIV_DUTY_STEPS;
  end

  pdsc_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .divisor_i (period_q),
    .rsp_o     (div_rsp)
  );

  // delta, wrap and code arithmetic
  always_comb begin
    raw   = $signed({2'b00, duty_q}) - $signed({2'b00, acc_q});
    mag   = raw[13] ? 14'(-raw) : 14'(raw);
    twice = {raw, 1'b0};
    fs_s  = $signed({3'b000, full_scale_q});
    fs14  = $signed({2'b00, full_scale_q});
    fwd   = (d_q > 14'sd0);
    gain_s = fwd ? $signed({1'b0, forward_gain_q}) : $signed({1'b0, reverse_gain_q});
    sum   = $signed({prod2_q[34], prod2_q}) + (fwd ? FWD_SUM_BASE : REV_SUM_BASE);
    code_full = sum[35:16];
    code  = STILL_CODE;
    sat   = 1'b0;
    if (moved_q) begin
      if (fwd) begin
        if (code_full > {9'd0, code_high_q}) begin
          code = code_high_q;
          sat  = 1'b1;
        end else begin
          code = code_full[10:0];
        end
      end else if (sum[35] || (code_full < {9'd0, code_low_q})) begin
        code = code_low_q;
        sat  = 1'b1;
      end else begin
        code = code_full[10:0];
      end
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    period_d    = period_q;
    high_ge_d   = high_ge_q;
    prod_d      = prod_q;
    duty_d      = duty_q;
    freq_d      = freq_q;
    acc_d       = acc_q;
    d_d         = d_q;
    moved_d     = moved_q;
    prod2_d     = prod2_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          period_d  = s_axis_tdata[31:0];
          high_ge_d = (s_axis_tdata[63:32] >= s_axis_tdata[31:0]);
          prod_d    = 44'(s_axis_tdata[63:32]) * 44'(full_scale_q);
          state_d   = ST_PREP;
        end
      end
      ST_PREP: begin
        if (period_q == '0) begin
          state_d = ST_DELTA;
        end else if (high_ge_q) begin
          duty_d  = full_scale_q;
          state_d = ST_DIVF;
        end else begin
          state_d = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (div_rsp.done) begin
          duty_d  = div_rsp.quot[11:0];
          state_d = ST_DIVF;
        end
      end
      ST_DIVF: begin
        if (div_rsp.done) begin
          freq_d  = div_rsp.quot;
          state_d = ST_DELTA;
        end
      end
      ST_DELTA: begin
        moved_d = (mag > {6'd0, still_band_q});
        if (twice > fs_s) begin
          d_d = raw - fs14;
        end else if (twice < -fs_s) begin
          d_d = raw + fs14;
        end else begin
          d_d = raw;
        end
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        prod2_d = 35'(d_q) * 35'(gain_s);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {3'b000, sat, moved_q, code, freq_q, duty_q};
          if (moved_q) begin
            acc_d = duty_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      period_q    <= '0;
      high_ge_q   <= 1'b0;
      prod_q      <= '0;
      duty_q      <= '0;
      freq_q      <= '0;
      acc_q       <= '0;
      d_q         <= '0;
      moved_q     <= 1'b0;
      prod2_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      period_q    <= period_d;
      high_ge_q   <= high_ge_d;
      prod_q      <= prod_d;
      duty_q      <= duty_d;
      freq_q      <= freq_d;
      acc_q       <= acc_d;
      d_q         <= d_d;
      moved_q     <= moved_d;
      prod2_q     <= prod2_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/pdsc_chk.sv =====
// ----------------------------------------------------------------------------
// PWM duty to speed code: port checker
// Watches the stream ports of the top level and flags broken handshakes and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pwm_duty_to_speed_code_core_defines.svh"

module pdsc_chk import pdsc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  `PDSC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled output word changed")
  `PDSC_ASSERT(a_one_at_a_time, in_fire |=> !s_axis_tready, "input taken while a word is in work")
  `PDSC_ASSERT(a_still_code, m_axis_tvalid && !m_axis_tdata[51] |-> m_axis_tdata[50:40] == STILL_CODE, "still word without still code")
  `PDSC_ASSERT_NEVER(a_sat_needs_move, m_axis_tvalid && m_axis_tdata[52] && !m_axis_tdata[51], "saturated word without movement")

endmodule

bind pwm_duty_to_speed_code_core pdsc_chk u_pdsc_chk (.*);
